// ===== hdl/cdcs_pkg.sv =====
// ----------------------------------------------------------------------------
// cdcs_pkg
// Shared types, codes and the deck word sequence table for the cassette deck
// command sequencer.
// ----------------------------------------------------------------------------
package cdcs_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [15:0] TAPE_END_TICKS_RST = 16'd47058;
	localparam logic [5:0]  DECK_LINES_RST     = 6'd18;

	typedef enum logic [1:0] {
		ACT_COMMAND = 2'd0,
		ACT_COUNTER = 2'd1,
		ACT_TICK    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_PLAY = 2'd1,
		MODE_FF   = 2'd2,
		MODE_REW  = 2'd3
	} mode_t;

	// active-high command bits after inversion
	localparam int unsigned CMD_STOP     = 0;
	localparam int unsigned CMD_AUTOREW  = 1;
	localparam int unsigned CMD_PLAY     = 2;
	localparam int unsigned CMD_AUTOPLAY = 4;
	localparam int unsigned CMD_FF       = 5;
	localparam int unsigned CMD_REW      = 7;

	// segment slots of a job, run lowest first
	localparam int unsigned SLOT_STOP0  = 0;
	localparam int unsigned SLOT_PRE    = 1;
	localparam int unsigned SLOT_PLAY   = 2;
	localparam int unsigned SLOT_STOP1  = 3;
	localparam int unsigned SLOT_FF     = 4;
	localparam int unsigned SLOT_STOP2  = 5;
	localparam int unsigned SLOT_REW    = 6;
	localparam int unsigned SLOT_STATUS = 7;
	localparam int unsigned NUM_SLOTS   = 8;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] slots;
		logic                 tape_end;
	} job_t;

	typedef struct packed {
		logic [5:0] word;
		logic [5:0] hold;
		logic       seg_end;
	} seq_entry_t;

	// table start of each word segment
	localparam logic [4:0] SEQ_STOP = 5'd0;
	localparam logic [4:0] SEQ_PRE  = 5'd2;
	localparam logic [4:0] SEQ_PLAY = 5'd3;
	localparam logic [4:0] SEQ_FF   = 5'd8;
	localparam logic [4:0] SEQ_REW  = 5'd13;

	function automatic logic [4:0] slot_start(input logic [2:0] slot);
		logic [4:0] s;
		case (slot)
			3'(SLOT_PRE):  s = SEQ_PRE;
			3'(SLOT_PLAY): s = SEQ_PLAY;
			3'(SLOT_FF):   s = SEQ_FF;
			3'(SLOT_REW):  s = SEQ_REW;
			default:       s = SEQ_STOP;
		endcase
		return s;
	endfunction

	function automatic seq_entry_t seq_rom(input logic [4:0] addr);
		seq_entry_t e;
		case (addr)
			5'd0:    e = '{6'd26, 6'd15, 1'b0};
			5'd1:    e = '{6'd18, 6'd0,  1'b1};
			5'd2:    e = '{6'd26, 6'd5,  1'b1};
			5'd3:    e = '{6'd18, 6'd5,  1'b0};
			5'd4:    e = '{6'd50, 6'd15, 1'b0};
			5'd5:    e = '{6'd18, 6'd35, 1'b0};
			5'd6:    e = '{6'd22, 6'd15, 1'b0};
			5'd7:    e = '{6'd18, 6'd0,  1'b1};
			5'd8:    e = '{6'd18, 6'd5,  1'b0};
			5'd9:    e = '{6'd50, 6'd15, 1'b0};
			5'd10:   e = '{6'd18, 6'd35, 1'b0};
			5'd11:   e = '{6'd19, 6'd15, 1'b0};
			5'd12:   e = '{6'd18, 6'd0,  1'b1};
			5'd13:   e = '{6'd16, 6'd5,  1'b0};
			5'd14:   e = '{6'd48, 6'd15, 1'b0};
			5'd15:   e = '{6'd16, 6'd15, 1'b0};
			5'd16:   e = '{6'd18, 6'd20, 1'b0};
			5'd17:   e = '{6'd19, 6'd15, 1'b0};
			5'd18:   e = '{6'd18, 6'd0,  1'b1};
			default: e = '{6'd18, 6'd0,  1'b1};
		endcase
		return e;
	endfunction

endpackage

// ===== hdl/cdcs_front.sv =====
// ----------------------------------------------------------------------------
// cdcs_front
// Accepts input words, keeps deck mode and tape-end timer, and turns each
// word that needs output into a job of word segments for the back end.
// ----------------------------------------------------------------------------
module cdcs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [7:0]          command_pins,
	input  logic                q_full,
	output logic                push,
	output cdcs_pkg::job_t      push_job
);

	logic [15:0]     ticks_q;
	cdcs_pkg::mode_t mode_q, mode_d;
	logic            first_q, first_d;
	logic [15:0]     cnt_q, cnt_d;
	logic            timer_q, timer_d;
	logic            te_q, te_d;

	logic [7:0]      act;
	logic [15:0]     cnt_inc;
	logic            accept;
	logic            has_job;
	cdcs_pkg::job_t  job;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign act      = ~(command_pins | 8'h08);
	assign cnt_inc  = cnt_q + 16'd1;

	always_comb begin
		cdcs_pkg::mode_t m;
		m          = mode_q;
		mode_d     = mode_q;
		first_d    = first_q;
		cnt_d      = cnt_q;
		timer_d    = timer_q;
		te_d       = te_q;
		job.slots  = '0;
		job.tape_end = te_q;
		case (cdcs_pkg::action_t'(action))
			cdcs_pkg::ACT_COMMAND: begin
				first_d = 1'b0;
				if (act[cdcs_pkg::CMD_STOP]) begin
					if (m != cdcs_pkg::MODE_STOP) job.slots[cdcs_pkg::SLOT_STOP0] = 1'b1;
					m = cdcs_pkg::MODE_STOP;
				end
				if (act[cdcs_pkg::CMD_PLAY] && m != cdcs_pkg::MODE_PLAY) begin
					if (m != cdcs_pkg::MODE_STOP) job.slots[cdcs_pkg::SLOT_PRE] = 1'b1;
					job.slots[cdcs_pkg::SLOT_PLAY] = 1'b1;
					m = cdcs_pkg::MODE_PLAY;
				end
				if (act[cdcs_pkg::CMD_FF]) begin
					if (m != cdcs_pkg::MODE_STOP) job.slots[cdcs_pkg::SLOT_STOP1] = 1'b1;
					job.slots[cdcs_pkg::SLOT_FF] = 1'b1;
					m = cdcs_pkg::MODE_FF;
				end
				if (act[cdcs_pkg::CMD_REW]) begin
					if (m != cdcs_pkg::MODE_STOP) job.slots[cdcs_pkg::SLOT_STOP2] = 1'b1;
					job.slots[cdcs_pkg::SLOT_REW] = 1'b1;
					m = cdcs_pkg::MODE_REW;
				end
				mode_d = m;
			end
			cdcs_pkg::ACT_COUNTER: begin
				cnt_d   = '0;
				timer_d = 1'b1;
				te_d    = 1'b0;
				job.tape_end = 1'b0;
				job.slots[cdcs_pkg::SLOT_STATUS] = 1'b1;
			end
			cdcs_pkg::ACT_TICK: begin
				if (timer_q) begin
					cnt_d = cnt_inc;
					if (cnt_inc >= ticks_q) begin
						timer_d = 1'b0;
						te_d    = 1'b1;
						job.tape_end = 1'b1;
						if (mode_q == cdcs_pkg::MODE_REW && act[cdcs_pkg::CMD_AUTOPLAY]
								&& !first_q) begin
							job.slots[cdcs_pkg::SLOT_PRE]  = 1'b1;
							job.slots[cdcs_pkg::SLOT_PLAY] = 1'b1;
							mode_d = cdcs_pkg::MODE_PLAY;
						end else if (mode_q == cdcs_pkg::MODE_PLAY
								&& act[cdcs_pkg::CMD_AUTOREW] && !first_q) begin
							job.slots[cdcs_pkg::SLOT_STOP2] = 1'b1;
							job.slots[cdcs_pkg::SLOT_REW]   = 1'b1;
							mode_d = cdcs_pkg::MODE_REW;
						end else begin
							job.slots[cdcs_pkg::SLOT_STATUS] = 1'b1;
							mode_d = cdcs_pkg::MODE_STOP;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign has_job  = |job.slots;
	assign push     = accept && has_job;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= cdcs_pkg::TAPE_END_TICKS_RST;
		end else if (cfg_wr_en) begin
			ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= cdcs_pkg::MODE_REW;
			first_q <= 1'b1;
			cnt_q   <= '0;
			timer_q <= 1'b0;
			te_q    <= 1'b1;
		end else if (accept) begin
			mode_q  <= mode_d;
			first_q <= first_d;
			cnt_q   <= cnt_d;
			timer_q <= timer_d;
			te_q    <= te_d;
		end
	end

endmodule

// ===== hdl/cdcs_queue.sv =====
// ----------------------------------------------------------------------------
// cdcs_queue
// Short job queue between the front end and the word sequencer.
// ----------------------------------------------------------------------------
module cdcs_queue #(
	parameter int unsigned DEPTH = cdcs_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cdcs_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output cdcs_pkg::job_t pop_job
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cdcs_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/cdcs_back.sv =====
// ----------------------------------------------------------------------------
// cdcs_back
// Word sequencer: walks each job's segments through the sequence table and
// drives one result word per cycle, unless stalled, into the output register.
// ----------------------------------------------------------------------------
module cdcs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  cdcs_pkg::job_t q_job,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [5:0]     deck_word,
	output logic [5:0]     hold_ms,
	output logic           word_valid,
	output logic           tape_end,
	output logic           last_of_run
);

	logic [cdcs_pkg::NUM_SLOTS-1:0] slots_q, slot_oh, rest;
	logic                           te_q;
	logic [2:0]                     off_q;
	logic [5:0]                     lines_q;

	logic                           out_valid_q;
	logic [5:0]                     word_q, hold_q;
	logic                           wvalid_q, te_out_q, last_q;

	logic [2:0]                     slot_idx;
	logic                           is_status, seg_end, produce;
	cdcs_pkg::seq_entry_t           entry;

	always_comb begin
		slot_idx = '0;
		for (int i = cdcs_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (slots_q[i]) slot_idx = 3'(i);
		end
	end

	assign slot_oh   = {{(cdcs_pkg::NUM_SLOTS-1){1'b0}}, 1'b1} << slot_idx;
	assign rest      = slots_q & ~slot_oh;
	assign is_status = (slot_idx == 3'(cdcs_pkg::SLOT_STATUS));
	assign entry     = cdcs_pkg::seq_rom(cdcs_pkg::slot_start(slot_idx) + {2'b00, off_q});
	assign seg_end   = is_status || entry.seg_end;
	assign produce   = (slots_q != '0) && (!out_valid_q || !out_stall);
	assign q_pop     = (slots_q == '0) && q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= '0;
			te_q    <= 1'b1;
			off_q   <= '0;
			lines_q <= cdcs_pkg::DECK_LINES_RST;
		end else if (q_pop) begin
			slots_q <= q_job.slots;
			te_q    <= q_job.tape_end;
			off_q   <= '0;
		end else if (produce) begin
			if (!is_status) lines_q <= entry.word;
			if (seg_end) begin
				slots_q <= rest;
				off_q   <= '0;
			end else begin
				off_q <= off_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// status-only words show the lines as last written
	always_ff @(posedge clk) begin
		if (produce) begin
			word_q   <= is_status ? lines_q : entry.word;
			hold_q   <= is_status ? 6'd0 : entry.hold;
			wvalid_q <= !is_status;
			te_out_q <= te_q;
			last_q   <= seg_end && (rest == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign deck_word   = word_q;
	assign hold_ms     = hold_q;
	assign word_valid  = wvalid_q;
	assign tape_end    = te_out_q;
	assign last_of_run = last_q;

endmodule

// ===== hdl/cassette_deck_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// cassette_deck_command_sequencer
// Turns command pin changes, tape counter edges and timer ticks into timed
// deck line words.
// ----------------------------------------------------------------------------
// The front end takes one input word per cycle while its job queue has room,
// updates the deck mode and tape-end timer at once and queues a job if the word
// needs output. The back end sends one result word per cycle while the output
// is not stalled, pausing between jobs to fetch the next from the queue; items
// that cause no result never reach the back end. The job queue depth sets how
// far the front end can run ahead of the output.
module cassette_deck_command_sequencer #(
	parameter int unsigned QUEUE_DEPTH = cdcs_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  command_pins,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  deck_word,
	output logic [5:0]  hold_ms,
	output logic        word_valid,
	output logic        tape_end,
	output logic        last_of_run
);

	logic           q_full, q_not_empty, push, pop;
	cdcs_pkg::job_t push_job, pop_job;

	cdcs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.command_pins (command_pins),
		.q_full       (q_full),
		.push         (push),
		.push_job     (push_job)
	);

	cdcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_job   (pop_job)
	);

	cdcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_job       (pop_job),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.deck_word   (deck_word),
		.hold_ms     (hold_ms),
		.word_valid  (word_valid),
		.tape_end    (tape_end),
		.last_of_run (last_of_run)
	);

endmodule

// ===== hdl/cdcs_checker.sv =====
// ----------------------------------------------------------------------------
// cdcs_checker
// Port-level checks on the result channel of the command sequencer.
// ----------------------------------------------------------------------------
module cdcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] deck_word,
	input logic [5:0] hold_ms,
	input logic       word_valid,
	input logic       tape_end,
	input logic       last_of_run
);

	// a stalled word stays offered
	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(deck_word) && $stable(hold_ms)
			&& $stable(word_valid) && $stable(tape_end) && $stable(last_of_run))
		else $error("stalled result word changed");

	// status-only words stand alone and carry no hold time
	a_status_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !word_valid |-> last_of_run && hold_ms == 6'd0)
		else $error("status word not alone in its run");

	// every run ends on a word with no hold time
	a_last_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run |-> hold_ms == 6'd0)
		else $error("run ends with a hold time");

endmodule

bind cassette_deck_command_sequencer cdcs_checker u_cdcs_checker (.*);
